### rtl/core/one_shot_timer_table_macros.svh
// assertion macros used by the port-level checker file
`ifndef ONE_SHOT_TIMER_TABLE_MACROS_SVH
`define ONE_SHOT_TIMER_TABLE_MACROS_SVH

// implication that holds in the same cycle
`define OST_ASSERT_NOW(label, cond, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |-> (prop)) \
        else $error(msg);

// implication that holds in the next cycle
`define OST_ASSERT_NEXT(label, cond, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

### rtl/core/ost_pkg.sv
// shared types and codes for the one-shot timer table
`default_nettype none

package ost_pkg;

    localparam int ID_W   = 8;
    localparam int TIME_W = 8;
    localparam int PL_W   = 16;
    localparam int KIND_W = 3;
    localparam int OP_W   = 2;

    // operation codes
    localparam logic [OP_W-1:0] OP_ADD     = 2'd0;
    localparam logic [OP_W-1:0] OP_ADD_UPD = 2'd1;
    localparam logic [OP_W-1:0] OP_TICK    = 2'd2;

    // result kinds
    localparam logic [KIND_W-1:0] KIND_STORED    = 3'd0;
    localparam logic [KIND_W-1:0] KIND_DROPPED   = 3'd1;
    localparam logic [KIND_W-1:0] KIND_FIRED     = 3'd2;
    localparam logic [KIND_W-1:0] KIND_TICK_NONE = 3'd3;
    localparam logic [KIND_W-1:0] KIND_IGNORED   = 3'd4;

    // fired results per tick are capped
    localparam int MAX_OUT = 8;
    localparam int NOUT_W  = 3;

    typedef struct packed {
        logic [PL_W-1:0]   payload;
        logic [TIME_W-1:0] deadline;
        logic [ID_W-1:0]   id;
    } t_slot;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [ID_W-1:0]   id;
        logic [PL_W-1:0]   payload;
        logic              running;
        logic              last;
    } t_result;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN_ADD,
        ST_ADD_END,
        ST_SCAN_TICK,
        ST_TICK_END,
        ST_EMIT,
        ST_RESP
    } t_state;

endpackage

`default_nettype wire

### rtl/core/ost_slot_mem.sv
// slot store: id, deadline and payload per slot, one write and one registered read port
`default_nettype none

module ost_slot_mem #(
    parameter int ENTRIES = 8
) (
    input  wire logic                                    i_clk,
    input  wire logic                                    i_wr_en,
    input  wire logic [(ENTRIES > 1 ? $clog2(ENTRIES) : 1)-1:0] i_wr_addr,
    input  wire ost_pkg::t_slot                          i_wr_slot,
    input  wire logic [(ENTRIES > 1 ? $clog2(ENTRIES) : 1)-1:0] i_rd_addr,
    output ost_pkg::t_slot                               o_rd_slot
);

    ost_pkg::t_slot r_mem [ENTRIES];
    ost_pkg::t_slot r_rd;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_slot;
        end
        r_rd <= r_mem[i_rd_addr];
    end

    assign o_rd_slot = r_rd;

endmodule

`default_nettype wire

### rtl/core/ost_ctrl.sv
// sequencer: walks the slots one per cycle for adds and ticks, frees fired slots
`default_nettype none

module ost_ctrl #(
    parameter int ENTRIES = 8
) (
    input  wire logic                                    i_clk,
    input  wire logic                                    i_rst_n,
    input  wire logic                                    i_in_valid,
    output logic                                         o_in_ready,
    input  wire logic [ost_pkg::OP_W-1:0]                i_op,
    input  wire logic [ost_pkg::ID_W-1:0]                i_id,
    input  wire logic [ost_pkg::TIME_W-1:0]              i_delay,
    input  wire logic [ost_pkg::PL_W-1:0]                i_payload,
    output logic [(ENTRIES > 1 ? $clog2(ENTRIES) : 1)-1:0] o_rd_addr,
    input  wire ost_pkg::t_slot                          i_rd_slot,
    output logic                                         o_wr_en,
    output logic [(ENTRIES > 1 ? $clog2(ENTRIES) : 1)-1:0] o_wr_addr,
    output ost_pkg::t_slot                               o_wr_slot,
    input  wire logic                                    i_out_free,
    output logic                                         o_res_load,
    output ost_pkg::t_result                             o_res
);

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam logic [IW-1:0] LAST_IDX = IW'(ENTRIES - 1);

    ost_pkg::t_state r_state, n_state;

    logic [ost_pkg::OP_W-1:0]   r_op, n_op;
    logic [ost_pkg::ID_W-1:0]   r_id, n_id;
    logic [ost_pkg::TIME_W-1:0] r_delay, n_delay;
    logic [ost_pkg::PL_W-1:0]   r_payload, n_payload;
    logic [ost_pkg::TIME_W-1:0] r_tick, n_tick;
    logic                       r_running, n_running;
    logic [ENTRIES-1:0]         r_valid, n_valid;
    logic [ENTRIES-1:0]         r_mask, n_mask;
    logic [IW-1:0]              r_idx, n_idx;
    logic                       r_hit, n_hit;
    logic [IW-1:0]              r_hit_idx, n_hit_idx;
    logic                       r_free, n_free;
    logic [IW-1:0]              r_free_idx, n_free_idx;
    logic                       r_any, n_any;
    logic [ost_pkg::NOUT_W-1:0] r_nout, n_nout;
    logic [ost_pkg::KIND_W-1:0] r_kind, n_kind;
    logic [ost_pkg::ID_W-1:0]   r_res_id, n_res_id;

    logic [IW-1:0]              idx_inc;
    logic                       cur_valid;
    logic [ENTRIES-1:0]         rem_mask;
    logic                       emit_last;
    logic [ost_pkg::TIME_W-1:0] deadline;
    logic [IW-1:0]              sel_idx;

    assign idx_inc   = r_idx + 1'b1;
    assign cur_valid = r_valid[r_idx];
    assign rem_mask  = r_mask & ~(ENTRIES'(1) << r_idx);
    assign emit_last = (rem_mask == '0) ||
                       (r_nout == ost_pkg::NOUT_W'(ost_pkg::MAX_OUT - 1));
    // one tick early when the source was stopped and the delay is nonzero
    assign deadline  = r_tick + r_delay +
                       ost_pkg::TIME_W'(r_running || (r_delay == '0));
    assign sel_idx   = r_hit ? r_hit_idx : r_free_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ost_pkg::ST_IDLE;
            r_tick    <= '0;
            r_running <= 1'b0;
            r_valid   <= '0;
        end else begin
            r_state   <= n_state;
            r_tick    <= n_tick;
            r_running <= n_running;
            r_valid   <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_id       <= n_id;
        r_delay    <= n_delay;
        r_payload  <= n_payload;
        r_mask     <= n_mask;
        r_idx      <= n_idx;
        r_hit      <= n_hit;
        r_hit_idx  <= n_hit_idx;
        r_free     <= n_free;
        r_free_idx <= n_free_idx;
        r_any      <= n_any;
        r_nout     <= n_nout;
        r_kind     <= n_kind;
        r_res_id   <= n_res_id;
    end

    always_comb begin
        n_state    = r_state;
        n_op       = r_op;
        n_id       = r_id;
        n_delay    = r_delay;
        n_payload  = r_payload;
        n_tick     = r_tick;
        n_running  = r_running;
        n_valid    = r_valid;
        n_mask     = r_mask;
        n_idx      = r_idx;
        n_hit      = r_hit;
        n_hit_idx  = r_hit_idx;
        n_free     = r_free;
        n_free_idx = r_free_idx;
        n_any      = r_any;
        n_nout     = r_nout;
        n_kind     = r_kind;
        n_res_id   = r_res_id;

        o_in_ready = 1'b0;
        o_rd_addr  = r_idx;
        o_wr_en    = 1'b0;
        o_wr_addr  = sel_idx;
        o_wr_slot  = '{payload: r_payload, deadline: deadline, id: r_id};
        o_res_load = 1'b0;
        o_res      = '{kind: r_kind, id: r_res_id, payload: '0,
                       running: r_running, last: 1'b1};

        case (r_state)
            ost_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                o_rd_addr  = '0;
                if (i_in_valid) begin
                    n_op      = i_op;
                    n_id      = i_id;
                    n_delay   = i_delay;
                    n_payload = i_payload;
                    n_idx     = '0;
                    n_hit     = 1'b0;
                    n_free    = 1'b0;
                    n_any     = 1'b0;
                    n_mask    = '0;
                    n_nout    = '0;
                    if ((i_op == ost_pkg::OP_ADD || i_op == ost_pkg::OP_ADD_UPD) &&
                        i_id != '0) begin
                        n_state = ost_pkg::ST_SCAN_ADD;
                    end else if (i_op == ost_pkg::OP_TICK && r_running) begin
                        n_tick  = r_tick + 1'b1;
                        n_state = ost_pkg::ST_SCAN_TICK;
                    end else begin
                        n_kind   = ost_pkg::KIND_IGNORED;
                        n_res_id = '0;
                        n_state  = ost_pkg::ST_RESP;
                    end
                end
            end
            ost_pkg::ST_SCAN_ADD: begin
                // a matching id wins over an earlier free slot
                if (r_op == ost_pkg::OP_ADD_UPD && cur_valid &&
                    i_rd_slot.id == r_id && !r_hit) begin
                    n_hit     = 1'b1;
                    n_hit_idx = r_idx;
                end
                if (!cur_valid && !r_free) begin
                    n_free     = 1'b1;
                    n_free_idx = r_idx;
                end
                if (r_idx == LAST_IDX) begin
                    n_state = ost_pkg::ST_ADD_END;
                end else begin
                    n_idx     = idx_inc;
                    o_rd_addr = idx_inc;
                end
            end
            ost_pkg::ST_ADD_END: begin
                n_res_id = r_id;
                if (r_hit || r_free) begin
                    o_wr_en          = 1'b1;
                    n_valid[sel_idx] = 1'b1;
                    n_running        = 1'b1;
                    n_kind           = ost_pkg::KIND_STORED;
                end else begin
                    n_kind = ost_pkg::KIND_DROPPED;
                end
                n_state = ost_pkg::ST_RESP;
            end
            ost_pkg::ST_SCAN_TICK: begin
                if (cur_valid) begin
                    if (i_rd_slot.deadline == r_tick) begin
                        n_valid[r_idx] = 1'b0;
                        n_mask[r_idx]  = 1'b1;
                    end else begin
                        n_any = 1'b1;
                    end
                end
                if (r_idx == LAST_IDX) begin
                    n_state = ost_pkg::ST_TICK_END;
                end else begin
                    n_idx     = idx_inc;
                    o_rd_addr = idx_inc;
                end
            end
            ost_pkg::ST_TICK_END: begin
                n_running = r_any;
                n_idx     = '0;
                o_rd_addr = '0;
                if (r_mask == '0) begin
                    n_kind   = ost_pkg::KIND_TICK_NONE;
                    n_res_id = '0;
                    n_state  = ost_pkg::ST_RESP;
                end else begin
                    n_state = ost_pkg::ST_EMIT;
                end
            end
            ost_pkg::ST_EMIT: begin
                if (r_mask[r_idx]) begin
                    if (i_out_free) begin
                        o_res_load    = 1'b1;
                        o_res         = '{kind: ost_pkg::KIND_FIRED, id: i_rd_slot.id,
                                          payload: i_rd_slot.payload,
                                          running: r_running, last: emit_last};
                        n_mask[r_idx] = 1'b0;
                        n_nout        = r_nout + 1'b1;
                        if (emit_last) begin
                            n_state = ost_pkg::ST_IDLE;
                        end else begin
                            n_idx     = idx_inc;
                            o_rd_addr = idx_inc;
                        end
                    end
                end else begin
                    n_idx     = idx_inc;
                    o_rd_addr = idx_inc;
                end
            end
            ost_pkg::ST_RESP: begin
                if (i_out_free) begin
                    o_res_load = 1'b1;
                    n_state    = ost_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = ost_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

### rtl/core/one_shot_timer_table.sv
// top level of the one-shot timer table: sequencer, slot store and result register
//
//  channel  | dir | tdata (low bit up)                          | tuser    | tlast
//  ---------+-----+---------------------------------------------+----------+-----------
//  s_axis   | in  | handler_id[7:0], delay_ticks[7:0], payload  | op[1:0]  | -
//  m_axis   | out | fired_id[7:0], fired_payload[15:0], running | kind     | last result
//
//  add / add or update: a scan of every slot, then the chosen slot is written, one result
//  tick: a scan of every slot, then one result per fired slot
//  ignored item: no scan, one result; scans run on the single slot read port, one slot a cycle
//  reset clears tick time, the running flag and the slot valid bits, no clearing pass
//  a stalled result port holds the sequencer; input is taken only between items
`default_nettype none

module one_shot_timer_table #(
    parameter int ENTRIES = 8
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,   // handler_id, delay_ticks, payload
    input  wire logic [1:0]  s_axis_tuser,   // op
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,   // fired_id, fired_payload, running, zero pad
    output logic [2:0]       m_axis_tuser,   // kind
    output logic             m_axis_tlast    // last result of the item
);

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    logic [IW-1:0]    rd_addr;
    ost_pkg::t_slot   rd_slot;
    logic             wr_en;
    logic [IW-1:0]    wr_addr;
    ost_pkg::t_slot   wr_slot;
    logic             out_free;
    logic             res_load;
    ost_pkg::t_result res;

    // result register, refilled in the cycle the held result is taken
    logic             r_out_valid;
    ost_pkg::t_result r_out;

    assign out_free = !r_out_valid || m_axis_tready;

    ost_ctrl #(
        .ENTRIES (ENTRIES)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_op       (s_axis_tuser),
        .i_id       (s_axis_tdata[7:0]),
        .i_delay    (s_axis_tdata[15:8]),
        .i_payload  (s_axis_tdata[31:16]),
        .o_rd_addr  (rd_addr),
        .i_rd_slot  (rd_slot),
        .o_wr_en    (wr_en),
        .o_wr_addr  (wr_addr),
        .o_wr_slot  (wr_slot),
        .i_out_free (out_free),
        .o_res_load (res_load),
        .o_res      (res)
    );

    // slot fields live in memory, valid bits stay in the sequencer
    ost_slot_mem #(
        .ENTRIES (ENTRIES)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_slot (wr_slot),
        .i_rd_addr (rd_addr),
        .o_rd_slot (rd_slot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_load) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_load) begin
            r_out <= res;
        end
    end

    // pack the result item
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {7'd0, r_out.running, r_out.payload, r_out.id};
    assign m_axis_tuser  = r_out.kind;
    assign m_axis_tlast  = r_out.last;

endmodule

`default_nettype wire

### rtl/core/ost_checker.sv
// port-level checks for the one-shot timer table, bound to the top level
`default_nettype none

`include "one_shot_timer_table_macros.svh"

module ost_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic [31:0] m_axis_tdata,
    input wire logic [2:0]  m_axis_tuser,
    input wire logic        m_axis_tlast
);

    logic in_fire;
    logic out_fired;
    logic out_other;

    assign in_fire   = s_axis_tvalid && s_axis_tready;
    assign out_fired = m_axis_tvalid && m_axis_tuser == ost_pkg::KIND_FIRED;
    assign out_other = m_axis_tvalid && m_axis_tuser != ost_pkg::KIND_FIRED;

    // one item at a time: no input right after one is taken
    `OST_ASSERT_NEXT(a_busy_after_accept, in_fire, !s_axis_tready, "ready right after accept")
    // id zero is never stored, so never fires
    `OST_ASSERT_NOW(a_fired_id_nonzero, out_fired, m_axis_tdata[7:0] != 8'd0, "fired id zero")
    // only fired results carry a payload, and they are the only multi-result kind
    `OST_ASSERT_NOW(a_single_result, out_other, m_axis_tlast && m_axis_tdata[23:8] == 16'd0, "non-fired result not single or has payload")
    // a stored timer always leaves the tick source running
    `OST_ASSERT_NOW(a_stored_running, m_axis_tvalid && m_axis_tuser == ost_pkg::KIND_STORED, m_axis_tdata[24], "stored without running")

endmodule

bind one_shot_timer_table ost_checker u_ost_checker (.*);

`default_nettype wire

### tb/tb_one_shot_timer_table.sv
// self-checking testbench for the one-shot timer table: random stream traffic against a predictor
`default_nettype none

module tb_one_shot_timer_table;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ENTRIES    = 8;
    localparam int RAND_ITEMS = 120;   // random adds and ticks after the directed part
    localparam int HOLD_AT    = 150;   // result count at which the long output hold starts
    localparam int HOLD_LEN   = 300;   // cycles of the long output hold
    localparam int IDLE_LIMIT = 2000;  // cycles with no handshake before giving up
    localparam int TAIL       = 2 * ENTRIES + 20;

    // op code that the block does not use
    localparam logic [ost_pkg::OP_W-1:0] OP_NONE = 2'd3;

    // one input item as the sender sees it
    typedef struct {
        logic [ost_pkg::OP_W-1:0]   op;
        logic [ost_pkg::ID_W-1:0]   id;
        logic [ost_pkg::TIME_W-1:0] dly;
        logic [ost_pkg::PL_W-1:0]   pl;
    } t_req;

    // clock and reset
    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    always #5ns i_clk = ~i_clk;

    // dut ports, inputs all known from time zero
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata  = '0;   // handler_id[7:0], delay_ticks[15:8], payload[31:16]
    logic [1:0]  s_axis_tuser  = '0;   // op
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;         // fired_id[7:0], fired_payload[23:8], running[24], pad
    logic [2:0]  m_axis_tuser;         // kind
    logic        m_axis_tlast;         // last result of the item

    one_shot_timer_table #(
        .ENTRIES(ENTRIES)
    ) u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // stimulus still to be offered, and results still owed by the block
    t_req             req_queue[$];
    ost_pkg::t_result owed_results[$];

    // predictor copy of the timer table
    logic [ost_pkg::TIME_W-1:0] tick_now;
    logic                       tick_on;
    logic                       tmr_live [ENTRIES];
    logic [ost_pkg::ID_W-1:0]   tmr_id   [ENTRIES];
    logic [ost_pkg::TIME_W-1:0] tmr_due  [ENTRIES];
    logic [ost_pkg::PL_W-1:0]   tmr_pl   [ENTRIES];

    // handshake flags seen at the last rising edge
    logic in_took  = 1'b0;
    logic out_took = 1'b0;

    int n_results = 0;
    int n_bad     = 0;
    int idle_cycles = 0;
    int hold_cnt  = 0;
    logic hold_on;

    // per-side idle control
    int tx_gap  = 0;
    bit tx_fast = 1'b0;
    int rx_wait = 0;
    bit rx_fast = 1'b0;

    task automatic push_req(input logic [ost_pkg::OP_W-1:0] op,
                            input logic [ost_pkg::ID_W-1:0] id,
                            input logic [ost_pkg::TIME_W-1:0] dly,
                            input logic [ost_pkg::PL_W-1:0] pl);
        t_req r;
        r.op  = op;
        r.id  = id;
        r.dly = dly;
        r.pl  = pl;
        req_queue.push_back(r);
    endtask

    // works out what one accepted item does to the table and queues its results
    task automatic predict_timer_results(input logic [ost_pkg::OP_W-1:0] op,
                                         input logic [ost_pkg::ID_W-1:0] id,
                                         input logic [ost_pkg::TIME_W-1:0] dly,
                                         input logic [ost_pkg::PL_W-1:0] pl);
        int               hit;
        bit               left;
        ost_pkg::t_result res[$];
        ost_pkg::t_result r;
        logic [ost_pkg::TIME_W-1:0] due;
        if ((op == ost_pkg::OP_ADD || op == ost_pkg::OP_ADD_UPD) && id != '0) begin
            hit = -1;
            for (int i = 0; i < ENTRIES; i++) begin
                // an update prefers the slot already owned by this id
                if (op == ost_pkg::OP_ADD_UPD && tmr_live[i] && tmr_id[i] == id) begin
                    hit = i;
                    break;
                end
                if (hit < 0 && !tmr_live[i]) begin
                    hit = i;
                    if (op == ost_pkg::OP_ADD) break;
                end
            end
            if (hit < 0) begin
                r = '{ost_pkg::KIND_DROPPED, id, 16'd0, 1'b0, 1'b0};
            end else begin
                due = tick_now + dly + 8'd1;
                // a stopped source restarts, one tick early for a nonzero delay
                if (!tick_on) begin
                    if (dly != '0) due = due - 8'd1;
                    tick_on = 1'b1;
                end
                tmr_live[hit] = 1'b1;
                tmr_id[hit]   = id;
                tmr_due[hit]  = due;
                tmr_pl[hit]   = pl;
                r = '{ost_pkg::KIND_STORED, id, 16'd0, 1'b0, 1'b0};
            end
            res.push_back(r);
        end else if (op == ost_pkg::OP_TICK && tick_on) begin
            left = 1'b0;
            tick_now = tick_now + 8'd1;
            for (int i = 0; i < ENTRIES; i++) begin
                if (tmr_live[i]) begin
                    if (tmr_due[i] == tick_now) begin
                        tmr_live[i] = 1'b0;
                        if (res.size() < ost_pkg::MAX_OUT) begin
                            r = '{ost_pkg::KIND_FIRED, tmr_id[i], tmr_pl[i], 1'b0, 1'b0};
                            res.push_back(r);
                        end
                    end else begin
                        left = 1'b1;
                    end
                end
            end
            if (!left) tick_on = 1'b0;
            if (res.size() == 0) begin
                r = '{ost_pkg::KIND_TICK_NONE, 8'd0, 16'd0, 1'b0, 1'b0};
                res.push_back(r);
            end
        end else begin
            // id zero, unused op, or tick while stopped
            r = '{ost_pkg::KIND_IGNORED, 8'd0, 16'd0, 1'b0, 1'b0};
            res.push_back(r);
        end
        foreach (res[k]) begin
            res[k].running = tick_on;
            res[k].last    = (k == res.size() - 1);
            owed_results.push_back(res[k]);
        end
    endtask

    // sender: offers queued items, waits a drawn gap after each accepted one
    always @(negedge i_clk) begin
        t_req r;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (s_axis_tvalid && !in_took) begin
            // item still waiting for ready, hold it
        end else if (tx_gap != 0) begin
            s_axis_tvalid <= 1'b0;
            tx_gap = tx_gap - 1;
        end else if (req_queue.size() != 0) begin
            r = req_queue.pop_front();
            s_axis_tvalid <= 1'b1;
            s_axis_tdata  <= {r.pl, r.dly, r.id};
            s_axis_tuser  <= r.op;
            // stretches of back-to-back items now and then
            if ($urandom_range(0, 31) == 0) tx_fast = !tx_fast;
            tx_gap = tx_fast ? 0 : $urandom_range(0, 16);
        end else begin
            s_axis_tvalid <= 1'b0;
        end
    end

    // long output hold, counted on its own so the block backs up into its input
    assign hold_on = (n_results >= HOLD_AT) && (hold_cnt < HOLD_LEN);

    always @(negedge i_clk) begin
        if (i_rst_n && hold_on) hold_cnt <= hold_cnt + 1;
    end

    // receiver: drops ready for a drawn stall after each accepted result
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (out_took) begin
                if ($urandom_range(0, 31) == 0) rx_fast = !rx_fast;
                rx_wait = rx_fast ? 0 : $urandom_range(0, 16);
            end
            if (hold_on) begin
                m_axis_tready <= 1'b0;
            end else if (rx_wait != 0) begin
                m_axis_tready <= 1'b0;
                rx_wait = rx_wait - 1;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // monitor: checks each result against the oldest owed one, then predicts new input
    always @(posedge i_clk) begin
        ost_pkg::t_result got;
        ost_pkg::t_result want;
        if (!i_rst_n) begin
            in_took  <= 1'b0;
            out_took <= 1'b0;
        end else begin
            in_took  <= s_axis_tvalid && s_axis_tready;
            out_took <= m_axis_tvalid && m_axis_tready;
            if (m_axis_tvalid && m_axis_tready) begin
                got.kind    = m_axis_tuser;
                got.id      = m_axis_tdata[7:0];
                got.payload = m_axis_tdata[23:8];
                got.running = m_axis_tdata[24];
                got.last    = m_axis_tlast;
                n_results  <= n_results + 1;
                if (owed_results.size() == 0) begin
                    n_bad = n_bad + 1;
                    if (n_bad <= 10)
                        $display("unexpected result: kind %0d id %02h pl %04h run %0b last %0b",
                                 got.kind, got.id, got.payload, got.running, got.last);
                end else begin
                    want = owed_results.pop_front();
                    if (got !== want) begin
                        n_bad = n_bad + 1;
                        if (n_bad <= 10)
                            $display({"result %0d: expected kind %0d id %02h pl %04h run %0b ",
                                      "last %0b, got kind %0d id %02h pl %04h run %0b last %0b"},
                                     n_results, want.kind, want.id, want.payload, want.running,
                                     want.last, got.kind, got.id, got.payload, got.running,
                                     got.last);
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                predict_timer_results(s_axis_tuser, s_axis_tdata[7:0], s_axis_tdata[15:8],
                                      s_axis_tdata[31:16]);
        end
    end

    // watchdog: any handshake restarts the count
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // stimulus, reset, and end of run
    initial begin
        int n_real;
        int pick;
        logic [ost_pkg::OP_W-1:0]   op;
        logic [ost_pkg::ID_W-1:0]   id;
        logic [ost_pkg::TIME_W-1:0] dly;

        tick_now = '0;
        tick_on  = 1'b0;
        for (int i = 0; i < ENTRIES; i++) begin
            tmr_live[i] = 1'b0;
            tmr_id[i]   = '0;
            tmr_due[i]  = '0;
            tmr_pl[i]   = '0;
        end

        // directed: tick while stopped, unused op, id zero on both adds
        push_req(ost_pkg::OP_TICK, 8'd0, 8'd0, 16'h0000);
        push_req(OP_NONE, 8'hFF, 8'hFF, 16'hFFFF);
        push_req(ost_pkg::OP_ADD, 8'd0, 8'd5, 16'h1234);
        push_req(ost_pkg::OP_ADD_UPD, 8'd0, 8'd5, 16'h1234);
        // zero delay while stopped, then fire it and stop again
        push_req(ost_pkg::OP_ADD, 8'd1, 8'd0, 16'h0000);
        push_req(ost_pkg::OP_TICK, 8'd0, 8'd0, 16'h0000);
        // longest delay while stopped, deadline wraps
        push_req(ost_pkg::OP_ADD, 8'hFF, 8'hFF, 16'hFFFF);
        // fill the rest of the table with one shared deadline
        for (int i = 2; i <= ENTRIES; i++)
            push_req(ost_pkg::OP_ADD, 8'(i), 8'd3, 16'(i * 16'h1111));
        // table full: plain add and new-id update drop, known-id update rewrites
        push_req(ost_pkg::OP_ADD, 8'd9, 8'd1, 16'h5555);
        push_req(ost_pkg::OP_ADD_UPD, 8'd9, 8'd1, 16'h5555);
        push_req(ost_pkg::OP_ADD_UPD, 8'd5, 8'd1, 16'hABCD);
        // ticks: none, the update fires, none, then many fire on one tick
        repeat (4) push_req(ost_pkg::OP_TICK, 8'd0, 8'd0, 16'h0000);

        // run tick time all the way round so the long timer fires across the wrap
        repeat (256) push_req(ost_pkg::OP_TICK, 8'd0, 8'd0, 16'h0000);

        // random: mostly adds on a small id pool and ticks, a little noise
        n_real = 0;
        while (n_real < RAND_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 4) begin
                if ($urandom_range(0, 1) == 0)
                    push_req(OP_NONE, 8'($urandom), 8'($urandom), 16'($urandom));
                else
                    push_req(2'($urandom_range(0, 1)), 8'd0, 8'($urandom), 16'($urandom));
            end else if (pick < 48) begin
                push_req(ost_pkg::OP_TICK, 8'($urandom), 8'($urandom), 16'($urandom));
                n_real++;
            end else begin
                op  = ($urandom_range(0, 1) == 0) ? ost_pkg::OP_ADD : ost_pkg::OP_ADD_UPD;
                id  = ($urandom_range(0, 4) != 0) ? 8'($urandom_range(1, 12))
                                                  : 8'($urandom_range(1, 255));
                dly = ($urandom_range(0, 6) != 0) ? 8'($urandom_range(0, 12))
                                                  : 8'($urandom_range(0, 255));
                push_req(op, id, dly, 16'($urandom));
                n_real++;
            end
        end

        // reset once, released on a falling edge
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // drain: all items taken, all results back, then a quiet tail
        // the sender only moves on falling edges, so look at rising ones
        while (req_queue.size() != 0 || s_axis_tvalid) @(posedge i_clk);
        while (owed_results.size() != 0) @(negedge i_clk);
        repeat (TAIL) @(negedge i_clk);

        if (n_bad == 0 && owed_results.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

`default_nettype wire
